[rtl/uqpf_pkg.sv]
// ----------------------------------------------------------------------------
// uqpf_pkg
// Shared types and constants for the UDP/QUIC priority filter.
// ----------------------------------------------------------------------------
package uqpf_pkg;

  localparam logic [15:0] POS_IPVER    = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SPORT_HI = 16'd34;
  localparam logic [15:0] POS_SPORT_LO = 16'd35;
  localparam logic [15:0] POS_DPORT_HI = 16'd36;
  localparam logic [15:0] POS_DPORT_LO = 16'd37;
  localparam logic [15:0] POS_ULEN_HI  = 16'd38;
  localparam logic [15:0] POS_ULEN_LO  = 16'd39;
  localparam logic [15:0] POS_QHDR     = 16'd42;
  localparam logic [15:0] POS_QVER_B3  = 16'd43;
  localparam logic [15:0] POS_QVER_B2  = 16'd44;
  localparam logic [15:0] POS_QVER_B1  = 16'd45;
  localparam logic [15:0] POS_QVER_B0  = 16'd46;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [16:0] UDP_START    = 17'd34;
  localparam logic [15:0] UDP_LEN_MIN  = 16'd10;
  localparam logic [3:0]  IP_V4        = 4'd4;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PRIO_LOW     = 8'h00;
  localparam logic [7:0]  PRIO_HIGH    = 8'h01;
  localparam logic [15:0] RELAY_PORT_RST = 16'd4242;

  localparam logic CFG_ADAPTIVE   = 1'b0;
  localparam logic CFG_RELAY_PORT = 1'b1;

  typedef enum logic [2:0] {
    CLS_NONE       = 3'd0,
    CLS_LONG       = 3'd1,
    CLS_SHORT_LOW  = 3'd2,
    CLS_SHORT_HIGH = 3'd3,
    CLS_SHORT_UNK  = 3'd4
  } frame_class_t;

  typedef struct packed {
    logic [3:0]  ipv_nibble;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_length;
    logic [7:0]  quic_hdr;
    logic [7:0]  quic_prio;
    logic [31:0] quic_version;
    logic [16:0] frame_len;
  } hdr_fields_t;

endpackage

[rtl/uqpf_capture.sv]
// ----------------------------------------------------------------------------
// uqpf_capture
// Byte position counter and header field capture, cleared at frame end.
// ----------------------------------------------------------------------------
module uqpf_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_en,
  input  logic [7:0]         byte_in,
  input  logic               byte_last,
  output uqpf_pkg::hdr_fields_t fields
);
  import uqpf_pkg::*;

  logic [15:0] pos_r,   pos_nxt;
  logic [3:0]  ipver_r, ipver_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] ulen_r,  ulen_nxt;
  logic [7:0]  qhdr_r,  qhdr_nxt;
  logic [7:0]  qprio_r, qprio_nxt;
  logic [31:0] qver_r,  qver_nxt;

  always_comb begin
    ipver_nxt = ipver_r;
    proto_nxt = proto_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    ulen_nxt  = ulen_r;
    qhdr_nxt  = qhdr_r;
    qprio_nxt = qprio_r;
    qver_nxt  = qver_r;
    if (pos_r == POS_IPVER)    ipver_nxt = byte_in[7:4];
    if (pos_r == POS_PROTO)    proto_nxt = byte_in;
    if (pos_r == POS_SPORT_HI) sport_nxt[15:8] = byte_in;
    if (pos_r == POS_SPORT_LO) sport_nxt[7:0] = byte_in;
    if (pos_r == POS_DPORT_HI) dport_nxt[15:8] = byte_in;
    if (pos_r == POS_DPORT_LO) dport_nxt[7:0] = byte_in;
    if (pos_r == POS_ULEN_HI)  ulen_nxt[15:8] = byte_in;
    if (pos_r == POS_ULEN_LO)  ulen_nxt[7:0] = byte_in;
    if (pos_r == POS_QHDR)     qhdr_nxt = byte_in;
    if (pos_r == POS_QVER_B3) begin
      qprio_nxt       = byte_in;
      qver_nxt[31:24] = qver_r[31:24] | byte_in;
    end
    if (pos_r == POS_QVER_B2)  qver_nxt[23:16] = qver_r[23:16] | byte_in;
    if (pos_r == POS_QVER_B1)  qver_nxt[15:8] = qver_r[15:8] | byte_in;
    if (pos_r == POS_QVER_B0)  qver_nxt[7:0] = qver_r[7:0] | byte_in;
    pos_nxt = (pos_r != POS_MAX) ? pos_r + 16'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && byte_last)) begin
      pos_r   <= '0;
      ipver_r <= '0;
      proto_r <= '0;
      sport_r <= '0;
      dport_r <= '0;
      ulen_r  <= '0;
      qhdr_r  <= '0;
      qprio_r <= '0;
      qver_r  <= '0;
    end else if (byte_en) begin
      pos_r   <= pos_nxt;
      ipver_r <= ipver_nxt;
      proto_r <= proto_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      ulen_r  <= ulen_nxt;
      qhdr_r  <= qhdr_nxt;
      qprio_r <= qprio_nxt;
      qver_r  <= qver_nxt;
    end
  end

  always_comb begin
    fields.ipv_nibble   = ipver_nxt;
    fields.protocol     = proto_nxt;
    fields.src_port     = sport_nxt;
    fields.dst_port     = dport_nxt;
    fields.udp_length   = ulen_nxt;
    fields.quic_hdr     = qhdr_nxt;
    fields.quic_prio    = qprio_nxt;
    fields.quic_version = qver_nxt;
    fields.frame_len    = {1'b0, pos_r} + 17'd1;
  end

endmodule

[rtl/udp_quic_priority_filter.sv]
// ----------------------------------------------------------------------------
// udp_quic_priority_filter
// Per-frame IPv4/UDP/QUIC header classifier with adaptive low-priority drop.
// ----------------------------------------------------------------------------
// Latency: the verdict is registered at the last byte's transfer and is offered
//   on the output in the following cycle.
// Throughput: one byte per cycle; capture and verdict logic sit before the
//   single output register, which frees in the cycle its result is taken.
// Reset (rst_n low, synchronous): capture state cleared, output empty,
//   adaptive mode off, relay port 4242.
module udp_quic_priority_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] drop, [3:1] frame_class,
                                  // [35:4] quic_version, [39:36] zero
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import uqpf_pkg::*;

  logic         adaptive_r;
  logic [15:0]  relay_port_r;
  logic         out_valid_r;
  logic         drop_r;
  frame_class_t class_r;
  logic [31:0]  version_r;

  hdr_fields_t  hdr;
  logic         in_xfer;
  logic         matched;
  logic         drop_nxt;
  frame_class_t class_nxt;
  logic [31:0]  version_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  uqpf_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_xfer),
    .byte_in   (in_tdata),
    .byte_last (in_tlast),
    .fields    (hdr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adaptive_r   <= 1'b0;
      relay_port_r <= RELAY_PORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ADAPTIVE:   adaptive_r   <= cfg_wdata[0];
        CFG_RELAY_PORT: relay_port_r <= cfg_wdata;
        default:        adaptive_r   <= adaptive_r;
      endcase
    end
  end

  always_comb begin
    matched = (hdr.ipv_nibble == IP_V4)
           && (hdr.protocol == PROTO_UDP)
           && (hdr.src_port == relay_port_r || hdr.dst_port == relay_port_r)
           && (hdr.udp_length >= UDP_LEN_MIN)
           && (({1'b0, hdr.udp_length} + UDP_START) <= hdr.frame_len);
    drop_nxt    = 1'b0;
    class_nxt   = CLS_NONE;
    version_nxt = '0;
    if (matched) begin
      priority if (hdr.quic_hdr[7]) begin
        class_nxt   = CLS_LONG;
        version_nxt = hdr.quic_version;
      end else if (hdr.quic_prio == PRIO_LOW) begin
        class_nxt = CLS_SHORT_LOW;
        drop_nxt  = adaptive_r;
      end else if (hdr.quic_prio == PRIO_HIGH) begin
        class_nxt = CLS_SHORT_HIGH;
      end else begin
        class_nxt = CLS_SHORT_UNK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      drop_r    <= drop_nxt;
      class_r   <= class_nxt;
      version_r <= version_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, version_r, class_r, drop_r};

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> out_valid_r)
    else $error("verdict not registered after last byte");

  a_drop_only_short_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && drop_r |-> class_r == CLS_SHORT_LOW && adaptive_r)
    else $error("drop outside short low class");

  a_version_only_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && class_r != CLS_LONG |-> version_r == 32'd0)
    else $error("version set for non-long class");

endmodule

[dv/tb_udp_quic_priority_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_udp_quic_priority_filter
// Feeds Ethernet frames one byte per transfer into the filter. A predictor
// captures the same header fields, works out the verdict for each frame and
// checks every verdict transfer. Directed frames cover each class and each
// rejection reason. Random frames are mostly well-formed QUIC over UDP, with
// some broken ones mixed in. The run changes the idle pattern and the
// register settings between phases and holds off the receiver for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_udp_quic_priority_filter;
  import uqpf_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned STALL_AT       = 800;
  localparam int unsigned STALL_LEN      = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_BYTES    = 360;
  localparam int unsigned PHASE_FRAMES   = 6;
  localparam logic [15:0] DIR_OTHER_PORT = 16'd4243;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } frame_byte_t;

  typedef struct packed {
    logic         drop;
    frame_class_t cls;
    logic [31:0]  version;
  } verdict_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] frame_byte
  logic        in_tlast   = 1'b0;   // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // [0] drop, [3:1] frame_class,
                                    // [35:4] quic_version, [39:36] zero
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = CFG_ADAPTIVE;
  logic [15:0] cfg_wdata  = 16'd0;

  udp_quic_priority_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  frame_byte_t pending_bytes[$];
  verdict_t    pending_verdicts[$];
  logic [7:0]  frame_buf[$];

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 52;
  logic [15:0] phase_relay   = RELAY_PORT_RST;
  int unsigned queued_bytes;
  int unsigned queued_frames;
  int unsigned mismatches    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_left    = 0;
  bit          stall_done    = 1'b0;
  bit          in_taken      = 1'b0;

  // predictor state
  logic        mdl_adaptive;
  logic [15:0] mdl_relay;
  logic [15:0] cap_pos;
  logic [3:0]  cap_ipver;
  logic [7:0]  cap_proto;
  logic [15:0] cap_sport;
  logic [15:0] cap_dport;
  logic [15:0] cap_ulen;
  logic [7:0]  cap_hdr;
  logic [7:0]  cap_prio;
  logic [31:0] cap_ver;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_capture_state();
    cap_pos   = '0;
    cap_ipver = '0;
    cap_proto = '0;
    cap_sport = '0;
    cap_dport = '0;
    cap_ulen  = '0;
    cap_hdr   = '0;
    cap_prio  = '0;
    cap_ver   = '0;
  endfunction

  function automatic bit classify_byte(input frame_byte_t fb, output verdict_t v);
    logic [16:0] frame_len;
    bit          hit;
    v = '0;
    v.cls = CLS_NONE;
    if (cap_pos != POS_MAX) begin
      case (cap_pos)
        POS_IPVER:    cap_ipver = fb.data[7:4];
        POS_PROTO:    cap_proto = fb.data;
        POS_SPORT_HI: cap_sport[15:8] = fb.data;
        POS_SPORT_LO: cap_sport[7:0] = fb.data;
        POS_DPORT_HI: cap_dport[15:8] = fb.data;
        POS_DPORT_LO: cap_dport[7:0] = fb.data;
        POS_ULEN_HI:  cap_ulen[15:8] = fb.data;
        POS_ULEN_LO:  cap_ulen[7:0] = fb.data;
        POS_QHDR:     cap_hdr = fb.data;
        POS_QVER_B3: begin
          cap_prio = fb.data;
          cap_ver[31:24] = fb.data;
        end
        POS_QVER_B2:  cap_ver[23:16] = fb.data;
        POS_QVER_B1:  cap_ver[15:8] = fb.data;
        POS_QVER_B0:  cap_ver[7:0] = fb.data;
        default: ;
      endcase
    end
    if (!fb.eof) begin
      if (cap_pos != POS_MAX) cap_pos = cap_pos + 16'd1;
      return 1'b0;
    end
    frame_len = {1'b0, cap_pos} + 17'd1;
    hit = cap_ipver == IP_V4 && cap_proto == PROTO_UDP
        && (cap_sport == mdl_relay || cap_dport == mdl_relay)
        && cap_ulen >= UDP_LEN_MIN && UDP_START + {1'b0, cap_ulen} <= frame_len;
    if (hit) begin
      if (cap_hdr[7]) begin
        v.cls = CLS_LONG;
        v.version = cap_ver;
      end else if (cap_prio == PRIO_LOW) begin
        v.cls = CLS_SHORT_LOW;
        v.drop = mdl_adaptive;
      end else if (cap_prio == PRIO_HIGH) begin
        v.cls = CLS_SHORT_HIGH;
      end else begin
        v.cls = CLS_SHORT_UNK;
      end
    end
    clear_capture_state();
    return 1'b1;
  endfunction

  function automatic void start_frame(input int unsigned len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back($urandom_range(0, 255));
  endfunction

  function automatic void put(input int unsigned pos, input logic [7:0] value);
    if (pos < frame_buf.size()) frame_buf[pos] = value;
  endfunction

  function automatic void shape_frame(input logic [3:0] ipv, input logic [7:0] proto,
                                      input logic [15:0] sp, dp, ulen,
                                      input logic [7:0] hdr, prio);
    put(POS_IPVER, {ipv, 4'($urandom_range(0, 15))});
    put(POS_PROTO, proto);
    put(POS_SPORT_HI, sp[15:8]);
    put(POS_SPORT_LO, sp[7:0]);
    put(POS_DPORT_HI, dp[15:8]);
    put(POS_DPORT_LO, dp[7:0]);
    put(POS_ULEN_HI, ulen[15:8]);
    put(POS_ULEN_LO, ulen[7:0]);
    put(POS_QHDR, hdr);
    put(POS_QVER_B3, prio);
  endfunction

  function automatic void queue_frame();
    foreach (frame_buf[i]) pending_bytes.push_back({frame_buf[i], i == frame_buf.size() - 1});
    queued_bytes += frame_buf.size();
    queued_frames++;
  endfunction

  function automatic void directed_frame(input int unsigned len, input logic [3:0] ipv,
                                         input logic [7:0] proto,
                                         input logic [15:0] sp, dp, ulen,
                                         input logic [7:0] hdr, prio);
    start_frame(len);
    shape_frame(ipv, proto, sp, dp, ulen, hdr, prio);
    queue_frame();
  endfunction

  function automatic logic [15:0] other_port();
    logic [15:0] p;
    do p = $urandom_range(0, 65535); while (p == phase_relay);
    return p;
  endfunction

  function automatic void add_random_frame();
    int unsigned len;
    logic [3:0]  ipv;
    logic [7:0]  proto, hdr, prio;
    logic [15:0] sp, dp, ulen;
    bit          raw;
    len   = $urandom_range(44, 64);
    ipv   = IP_V4;
    proto = PROTO_UDP;
    raw   = 1'b0;
    sp    = other_port();
    dp    = other_port();
    case ($urandom_range(0, 2))
      0: sp = phase_relay;
      1: dp = phase_relay;
      default: begin
        sp = phase_relay;
        dp = phase_relay;
      end
    endcase
    ulen = $urandom_range(0, 1) ? 16'(len - 34) : 16'($urandom_range(10, len - 34));
    hdr  = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: prio = PRIO_LOW;
      1: prio = PRIO_HIGH;
      default: prio = $urandom_range(0, 255);
    endcase
    // break roughly a quarter of the frames
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 6))
        0: begin
          do ipv = $urandom_range(0, 15); while (ipv == IP_V4);
        end
        1: begin
          do proto = $urandom_range(0, 255); while (proto == PROTO_UDP);
        end
        2: begin
          sp = other_port();
          dp = other_port();
        end
        3: ulen = $urandom_range(0, 9);
        4: ulen = $urandom_range(len - 33, 65535);
        5: len = $urandom_range(1, 46);
        default: raw = 1'b1;
      endcase
    end
    start_frame(len);
    if (!raw) shape_frame(ipv, proto, sp, dp, ulen, hdr, prio);
    queue_frame();
  endfunction

  task automatic write_reg(input logic addr, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_tvalid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned s_pct, r_pct, input logic adaptive,
                           input logic [15:0] relay);
    write_reg(CFG_ADAPTIVE, {15'd0, adaptive});
    write_reg(CFG_RELAY_PORT, relay);
    phase_relay   = relay;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    queued_bytes  = 0;
    queued_frames = 0;
    while (queued_bytes < PHASE_BYTES || queued_frames < PHASE_FRAMES) add_random_frame();
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // long header, all ones
    start_frame(47);
    shape_frame(IP_V4, PROTO_UDP, phase_relay, DIR_OTHER_PORT, 16'd13, 8'hFF, 8'hFF);
    put(POS_QVER_B2, 8'hFF);
    put(POS_QVER_B1, 8'hFF);
    put(POS_QVER_B0, 8'hFF);
    queue_frame();
    // long header with three of its version bytes beyond the last byte
    directed_frame(44, IP_V4, PROTO_UDP, DIR_OTHER_PORT, phase_relay, 16'd10, 8'h80, 8'hA5);
    directed_frame(48, IP_V4, PROTO_UDP, DIR_OTHER_PORT, phase_relay, 16'd14, 8'h00, PRIO_LOW);
    directed_frame(47, IP_V4, PROTO_UDP, phase_relay, DIR_OTHER_PORT, 16'd13, 8'h7F, PRIO_HIGH);
    directed_frame(50, IP_V4, PROTO_UDP, phase_relay, phase_relay, 16'd16, 8'h00, 8'hFF);
    directed_frame(47, 4'd6, PROTO_UDP, phase_relay, phase_relay, 16'd13, 8'h00, PRIO_HIGH);
    directed_frame(47, IP_V4, 8'd6, phase_relay, phase_relay, 16'd13, 8'h00, PRIO_HIGH);
    directed_frame(47, IP_V4, PROTO_UDP, DIR_OTHER_PORT, DIR_OTHER_PORT, 16'd13, 8'h00,
                   PRIO_HIGH);
    directed_frame(44, IP_V4, PROTO_UDP, phase_relay, phase_relay, 16'd9, 8'h00, PRIO_HIGH);
    // UDP payload one byte past the frame
    directed_frame(44, IP_V4, PROTO_UDP, phase_relay, phase_relay, 16'd11, 8'h00, PRIO_HIGH);
    start_frame(1);
    frame_buf[0] = 8'hFF;
    queue_frame();
    start_frame(46);
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    queue_frame();
    drain();

    run_phase(11, 52, 1'b1, 16'hFFFF);
    run_phase(52, 11, 1'b0, 16'h0000);
    run_phase(0, 0, 1'b1, 16'($urandom_range(0, 65535)));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(negedge clk) begin
    frame_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.eof;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && bytes_taken >= STALL_AT) begin
      // hold off the receiver so the block backs up into its input
      out_tready <= 1'b0;
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      in_taken     = 1'b0;
      mdl_adaptive = 1'b0;
      mdl_relay    = RELAY_PORT_RST;
      clear_capture_state();
    end else begin
      in_taken = in_tvalid && in_tready;
      if (cfg_we) begin
        if (cfg_addr == CFG_ADAPTIVE) mdl_adaptive = cfg_wdata[0];
        else mdl_relay = cfg_wdata;
      end
      if (in_taken) begin
        bytes_taken++;
        if (classify_byte({in_tdata, in_tlast}, want)) pending_verdicts.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected verdict transfer drop=%0d class=%0d version=%h",
                     $realtime, out_tdata[0], out_tdata[3:1], out_tdata[35:4]);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.drop || out_tdata[3:1] !== want.cls
              || out_tdata[35:4] !== want.version || out_tdata[39:36] !== 4'd0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: verdict mismatch exp drop=%0d class=%0d version=%h, got %h",
                       $realtime, want.drop, want.cls, want.version, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
